// ----- hw/rtl/cfn_crc_pkg.sv -----
package cfn_crc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_UPPER_A = 8'h41;
  localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
  localparam logic [7:0] BYTE_CASE_OFS = 8'h20;
  localparam logic [7:0] BYTE_SLASH = 8'h2F;
  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;

  typedef logic [31:0] crc_t;
  typedef logic [7:0] name_byte_t;

  function automatic name_byte_t fold_byte(input name_byte_t b);
    name_byte_t f;
    if (b >= BYTE_UPPER_A && b <= BYTE_UPPER_Z) begin
      f = b + BYTE_CASE_OFS;
    end else if (b == BYTE_SLASH) begin
      f = BYTE_BACKSLASH;
    end else begin
      f = b;
    end
    return f;
  endfunction

  // reflected crc-32, one byte, logical shift
  function automatic crc_t crc_byte(input crc_t crc, input name_byte_t b);
    crc_t c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/case_folded_name_crc32_hash_core.sv -----
// case-folded file-name crc-32 hash core
// result: out_valid is registered and rises when a terminating zero byte leaves the input register
// throughput: one byte per cycle, set by the single-byte crc update between the
//   input register and the crc register; input stalls only while a terminating
//   byte waits behind a result word that has not been taken
// reset: synchronous active-low rst_n clears valids and reloads crc with all ones
module case_folded_name_crc32_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_name_id
);

  logic                   s1_valid_r;
  cfn_crc_pkg::name_byte_t s1_byte_r;
  cfn_crc_pkg::crc_t      crc_r;
  cfn_crc_pkg::crc_t      crc_nxt;
  logic                   out_valid_r;
  cfn_crc_pkg::crc_t      out_id_r;
  logic                   s1_term;
  logic                   s1_go;
  logic                   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign s1_term  = (s1_byte_r == cfn_crc_pkg::BYTE_NUL);
  assign s1_go    = s1_valid_r && (!s1_term || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    crc_nxt = crc_r;
    if (s1_go) begin
      if (s1_term) begin
        crc_nxt = cfn_crc_pkg::CRC_INIT;
      end else begin
        crc_nxt = cfn_crc_pkg::crc_byte(crc_r, cfn_crc_pkg::fold_byte(s1_byte_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      crc_r       <= cfn_crc_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go && s1_term) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_name_byte;
    end
    if (s1_go && s1_term) begin
      out_id_r <= crc_r ^ cfn_crc_pkg::CRC_XOROUT;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_name_id = out_id_r;

  a_term_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_term) |=> out_valid_r)
    else $error("terminating byte did not produce a word");

  a_term_reloads_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_term) |=> (crc_r == cfn_crc_pkg::CRC_INIT))
    else $error("crc not reloaded after terminating byte");

  a_stall_only_on_term: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_term && out_valid_r && !out_ready))
    else $error("input stalled without a blocked terminating byte");

  a_crc_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |=> $stable(crc_r))
    else $error("crc changed with no byte in stage");

endmodule
